// ===== hw/rtl/rmeu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmeu_pkg
// Shared types and constants for the register machine execute unit.
// ----------------------------------------------------------------------------
package rmeu_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int NUM_REGS  = 32;
  localparam int MEM_AW    = $clog2(MEM_BYTES / 4);
  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam logic [31:0] X2_RESET = 32'(MEM_BYTES / 2 - 1);

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_ADDI = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_BEQ = 5'd7, OP_BNE = 5'd8, OP_BLT = 5'd9,
    OP_BGT = 5'd10, OP_BLE = 5'd11, OP_BGE = 5'd12, OP_JUMP = 5'd13,
    OP_JALR = 5'd14, OP_JR = 5'd15, OP_LW = 5'd16, OP_LH = 5'd17, OP_LB = 5'd18,
    OP_SW = 5'd19, OP_SH = 5'd20, OP_SB = 5'd21, OP_LI = 5'd22, OP_MOVE = 5'd23,
    OP_SETLINE = 5'd24
  } op_t;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DIV0 = 2'd1;
  localparam logic [1:0] FAULT_ADDR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_MEM, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // capture input word, read registers
    logic exec;       // evaluate the op, commit register and line updates
    logic div_start;
    logic div_step;
    logic div_done;
    logic mem_done;   // load data available
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_div;
    logic is_load;
    logic div_last;
  } sts_t;

endpackage

// ===== hw/rtl/rmeu_ram.sv =====
// ----------------------------------------------------------------------------
// rmeu_ram
// Generic single-port RAM with byte enables and registered read.
// ----------------------------------------------------------------------------
module rmeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [WIDTH/8-1:0]       be,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIDTH / 8; i++) begin
      if (we && be[i]) mem[addr][i*8 +: 8] <= wdata[i*8 +: 8];
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/rmeu_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmeu_ctrl
// Sequencer: accept, execute, optional divide or memory read, deliver.
// ----------------------------------------------------------------------------
module rmeu_ctrl import rmeu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_tvalid,
  output logic   in_tready,
  output logic   out_tvalid,
  input  logic   out_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (sts.is_div)       state_nxt = ST_DIV;
        else if (sts.is_load) state_nxt = ST_MEM;
        else                  state_nxt = ST_OUT;
      end
      ST_DIV:  if (sts.div_last) state_nxt = ST_OUT;
      ST_MEM:  state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = sts.is_div;
      end
      ST_DIV: begin
        cmd.div_step = !sts.div_last;
        cmd.div_done = sts.div_last;
      end
      ST_MEM: cmd.mem_done = 1'b1;
      ST_OUT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/rmeu_dp.sv =====
// ----------------------------------------------------------------------------
// rmeu_dp
// Datapath: register file, line counter, ALU, serial divider, data memory.
// ----------------------------------------------------------------------------
module rmeu_dp import rmeu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  req_type,
  input  logic [4:0]  reg_dest,
  input  logic [4:0]  reg_src1,
  input  logic [4:0]  reg_src2,
  input  logic [31:0] imm,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [31:0] dest_value,
  output logic        reg_written,
  output logic [31:0] next_line,
  output logic        jumped,
  output logic [1:0]  fault
);

  logic [31:0] regs_r [NUM_REGS];
  logic [31:0] line_r;
  logic [4:0]  op_r, rd_r;
  logic [31:0] a_r, b_r, d_r, imm_r;

  logic [31:0] dv_r, dv_nxt;
  logic        rw_r, rw_nxt, jmp_r, jmp_nxt;
  logic [1:0]  flt_r, flt_nxt;
  logic [REG_AW-1:0] wix_r, wix_nxt;

  // divider
  logic [31:0] q_r, rem_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        qneg_r;
  logic [32:0] trial;

  function automatic logic [31:0] rdreg(input logic [4:0] idx);
    logic [31:0] v;
    v = '0;
    if (idx != 5'd0 && 32'(idx) < NUM_REGS) v = regs_r[idx[REG_AW-1:0]];
    return v;
  endfunction

  // memory: four byte-wide banks, bank j holds the bytes whose address is j mod 4
  logic              mem_we;
  logic [3:0]        lane_mask, lane_en;
  logic [7:0]        lane_rot;
  logic [31:0]       bank_rd;
  logic [63:0]       rd_rot;
  logic [MEM_AW-1:0] word_a;
  logic [1:0]        boff;
  logic [2:0]        size;
  logic [32:0]       aend;
  logic              addr_bad, is_mem, is_store;

  assign boff     = imm_r[1:0];
  assign is_mem   = op_r >= OP_LW && op_r <= OP_SB;
  assign is_store = op_r >= OP_SW && op_r <= OP_SB;
  always_comb begin
    size = 3'd1;
    if (op_r == OP_LW || op_r == OP_SW) size = 3'd4;
    if (op_r == OP_LH || op_r == OP_SH) size = 3'd2;
  end
  assign aend     = {1'b0, imm_r} + 33'(size);
  assign addr_bad = imm_r[31] || aend > 33'(MEM_BYTES);
  assign word_a   = imm_r[MEM_AW+1:2];
  always_comb begin
    unique case (size)
      3'd4:    lane_mask = 4'b1111;
      3'd2:    lane_mask = 4'b0011;
      default: lane_mask = 4'b0001;
    endcase
    lane_rot = {4'b0000, lane_mask} << boff;
    lane_en  = lane_rot[3:0] | lane_rot[7:4];
  end
  assign mem_we = cmd.exec && is_store && !addr_bad;

  // banks below the byte offset hold the part of a span that spills into the next word
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [1:0]        wsel;
    logic [31:0]       wsh;
    logic [MEM_AW-1:0] bank_a;
    assign wsel   = 2'(j) - boff;
    assign wsh    = d_r >> {wsel, 3'b000};
    assign bank_a = word_a + {{(MEM_AW-1){1'b0}}, (2'(j) < boff)};
    rmeu_ram #(.WIDTH(8), .DEPTH(MEM_WORDS)) u_ram (
      .clk, .we(mem_we), .be(lane_en[j]), .addr(bank_a), .wdata(wsh[7:0]),
      .rdata(bank_rd[8*j +: 8])
    );
  end

  assign sts.is_div   = op_r == OP_DIV && b_r != '0;
  assign sts.is_load  = is_mem && !is_store && !addr_bad;
  assign sts.div_last = cnt_r == 6'd32;

  logic signed [31:0] sa, sb;
  logic [31:0] lnp1, immp1, ld_sh;
  logic        cond, wok;
  assign sa     = a_r;
  assign sb     = b_r;
  assign lnp1   = a_r + 32'd1;
  assign immp1  = imm_r + 32'd1;
  assign rd_rot = {bank_rd, bank_rd} >> {boff, 3'b000};
  assign ld_sh  = rd_rot[31:0];
  assign trial  = {rem_r, q_r[31]} - {1'b0, dvs_r};

  always_comb begin
    cond = 1'b0;
    case (op_r)
      OP_BEQ:  cond = sa == sb;
      OP_BNE:  cond = sa != sb;
      OP_BLT:  cond = sa < sb;
      OP_BGT:  cond = sa > sb;
      OP_BLE:  cond = sa <= sb;
      OP_BGE:  cond = sa >= sb;
      OP_JUMP: cond = 1'b1;
      default: cond = 1'b0;
    endcase
  end

  function automatic logic wr_ok(input logic [4:0] idx);
    return idx != 5'd0 && 32'(idx) < NUM_REGS;
  endfunction

  logic [31:0] line_nxt, val;
  logic        has_val, do_jmp;
  logic [4:0]  wdst;

  always_comb begin
    val = '0; has_val = 1'b0; do_jmp = 1'b0; line_nxt = line_r;
    wdst = rd_r; flt_nxt = FAULT_NONE;
    case (op_r) inside
      OP_ADD:  begin val = a_r + b_r;   has_val = 1'b1; end
      OP_ADDI: begin val = a_r + imm_r; has_val = 1'b1; end
      OP_SUB:  begin val = a_r - b_r;   has_val = 1'b1; end
      OP_MUL:  begin val = a_r * b_r;   has_val = 1'b1; end
      OP_DIV:  if (b_r == '0) flt_nxt = FAULT_DIV0;
      OP_AND:  begin val = 32'(a_r != '0 && b_r != '0); has_val = 1'b1; end
      OP_OR:   begin val = 32'(a_r != '0 || b_r != '0); has_val = 1'b1; end
      OP_JALR: begin
        val = line_r; has_val = 1'b1; wdst = 5'd1; do_jmp = 1'b1; line_nxt = lnp1;
      end
      OP_JR:      begin do_jmp = 1'b1; line_nxt = a_r; end
      OP_LI:      begin val = imm_r; has_val = 1'b1; end
      OP_MOVE:    begin val = a_r;   has_val = 1'b1; end
      OP_SETLINE: begin do_jmp = 1'b1; line_nxt = imm_r; end
      OP_LW, OP_LH, OP_LB, OP_SW, OP_SH, OP_SB:
        if (addr_bad) flt_nxt = FAULT_ADDR;
      default: ;
    endcase
    if (op_r >= OP_BEQ && op_r <= OP_JUMP && cond) begin
      do_jmp = 1'b1; line_nxt = immp1;
    end
    wok     = has_val && wr_ok(wdst);
    dv_nxt  = wok ? val : '0;
    rw_nxt  = wok;
    jmp_nxt = do_jmp;
    wix_nxt = wdst[REG_AW-1:0];
  end

  logic [31:0] ld_val, q_fix;
  always_comb begin
    unique case (op_r)
      OP_LW:   ld_val = ld_sh;
      OP_LH:   ld_val = {16'd0, ld_sh[15:0]};
      default: ld_val = {{24{ld_sh[7]}}, ld_sh[7:0]};
    endcase
  end
  assign q_fix = qneg_r ? (32'd0 - q_r) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
      regs_r[1] <= '1;
      regs_r[2] <= X2_RESET;
      line_r    <= '0;
    end else begin
      if (cmd.exec) begin
        if (rw_nxt) regs_r[wix_nxt] <= val;
        if (jmp_nxt) line_r <= line_nxt;
      end
      if (cmd.div_done && wr_ok(rd_r)) regs_r[wix_r] <= q_fix;
      if (cmd.mem_done && wr_ok(rd_r)) regs_r[wix_r] <= ld_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= req_type;
      rd_r  <= reg_dest;
      a_r   <= rdreg(reg_src1);
      b_r   <= rdreg(reg_src2);
      d_r   <= rdreg(reg_dest);
      imm_r <= imm;
    end
    if (cmd.exec) begin
      dv_r <= dv_nxt; rw_r <= rw_nxt; jmp_r <= jmp_nxt; flt_r <= flt_nxt;
      wix_r <= wix_nxt;
    end
    if (cmd.div_start) begin
      q_r    <= a_r[31] ? 32'd0 - a_r : a_r;
      dvs_r  <= b_r[31] ? 32'd0 - b_r : b_r;
      rem_r  <= '0;
      qneg_r <= a_r[31] ^ b_r[31];
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      // restoring divide, one quotient bit per cycle
      if (!trial[32]) rem_r <= trial[31:0];
      else            rem_r <= {rem_r[30:0], q_r[31]};
      q_r   <= {q_r[30:0], !trial[32]};
      cnt_r <= cnt_r + 6'd1;
    end
    if (cmd.div_done) begin
      dv_r <= wr_ok(rd_r) ? q_fix : '0; rw_r <= wr_ok(rd_r);
    end
    if (cmd.mem_done) begin
      dv_r <= wr_ok(rd_r) ? ld_val : '0; rw_r <= wr_ok(rd_r);
    end
  end

  // quotient is complete in the cycle after the 32nd step, when div_done is raised
  assign dest_value  = dv_r;
  assign reg_written = rw_r;
  assign next_line   = line_r;
  assign jumped      = jmp_r;
  assign fault       = flt_r;

endmodule

// ===== hw/rtl/register_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// register_machine_execute_unit
// Executes one decoded instruction per input word.
// ----------------------------------------------------------------------------
// One instruction in, one result word out. A word passes through accept, execute
// and deliver for register, branch, store and faulting ops; loads add a
// registered memory read, and div adds the divide state, where the radix-2
// divider makes one quotient bit a cycle and a final step takes the sign-fixed
// quotient. The result is held while the receiver holds off. A new word is
// accepted once the previous result is taken. Accesses at any byte alignment
// are served in a single access by four byte-wide banks.
module register_machine_execute_unit import rmeu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[4:0], reg_dest[9:5], reg_src1[14:10], reg_src2[19:15], imm[51:20]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // dest_value[31:0], reg_written[32], next_line[64:33], jumped[65], fault[67:66]
  output logic [71:0] out_tdata
);

  cmd_t cmd;
  sts_t sts;
  logic [31:0] dest_value, next_line;
  logic        reg_written, jumped;
  logic [1:0]  fault;

  rmeu_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .sts, .cmd
  );

  rmeu_dp u_dp (
    .clk, .rst_n,
    .req_type(in_tdata[4:0]), .reg_dest(in_tdata[9:5]), .reg_src1(in_tdata[14:10]),
    .reg_src2(in_tdata[19:15]), .imm(in_tdata[51:20]),
    .cmd, .sts, .dest_value, .reg_written, .next_line, .jumped, .fault
  );

  assign out_tdata = {4'd0, fault, jumped, next_line, reg_written, dest_value};

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("accept while result pending");
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && fault != FAULT_NONE |-> !reg_written && !jumped)
    else $error("fault with side effect");
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !reg_written |-> dest_value == '0)
    else $error("nonzero value without write");

endmodule
